/* design/ed_pkg.sv */
// Shared types and constants for the edit distance engine.
package ed_pkg;

  // Default string capacity and the fixed width of the distance field
  localparam int MAX_LEN_DEF = 256;
  localparam int DIST_W      = 9;

  // Request action codes
  localparam logic [1:0] ACT_FIRST   = 2'd0;
  localparam logic [1:0] ACT_SECOND  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

endpackage

/* design/edit_distance_engine.sv */
// Load request: accepted when idle, byte stored by the next edge; a load adds no stall.
// Compute request: cells of the na-by-nb table (na, nb = short and long lengths) pass one
// at a time through the shared cell unit, each in a read state then a calc state, set by
// the registered read of the string and cost memories; an empty string goes to the result.
// The request side stalls from compute acceptance until the result is placed in the output register.
// Synchronous reset clears lengths, overflow flag, sequencer and result valid; memories hold.
module edit_distance_engine import ed_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int CW    = $clog2(MAX_LEN + 2);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_DONE} state_t;

  state_t          state;
  logic [LW-1:0]   first_length;
  logic [LW-1:0]   second_length;
  logic            overflow_seen;
  logic [LW-1:0]   na;
  logic [LW-1:0]   nb;
  logic            swap;
  logic            ovf_hold;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [CW-1:0]   diag;
  logic [CW-1:0]   left;
  logic [CW-1:0]   final_cost;

  // storage
  logic [7:0]      first_mem  [MAX_LEN];
  logic [7:0]      second_mem [MAX_LEN];
  logic [CW-1:0]   cost_mem   [MAX_LEN];
  logic [7:0]      first_rd;
  logic [7:0]      second_rd;
  logic [CW-1:0]   cost_rd;

  logic            accept;
  logic            wr_first;
  logic            wr_second;
  logic [IDX_W-1:0] first_addr;
  logic [IDX_W-1:0] second_addr;
  logic [7:0]      row_byte;
  logic [7:0]      col_byte;
  logic [CW-1:0]   up;
  logic [CW-1:0]   cell_cost;
  logic            last_i;
  logic            last_j;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  assign wr_first  = accept && (item.action == ACT_FIRST) && (first_length < LW'(MAX_LEN));
  assign wr_second = accept && (item.action == ACT_SECOND) && (second_length < LW'(MAX_LEN));

  // the shorter string indexes the row (i), the longer one the column (j)
  assign first_addr  = wr_first  ? first_length[IDX_W-1:0]  : (swap ? j : i);
  assign second_addr = wr_second ? second_length[IDX_W-1:0] : (swap ? i : j);
  assign row_byte    = swap ? second_rd : first_rd;
  assign col_byte    = swap ? first_rd  : second_rd;

  // first row of the table is i+1 without a memory init sweep
  assign up     = (j == '0) ? CW'(i) + CW'(1) : cost_rd;
  assign last_i = (LW'(i) == na - LW'(1));
  assign last_j = (LW'(j) == nb - LW'(1));

  ed_cell #(.CW(CW)) u_cell (
    .diag  (diag),
    .up    (up),
    .left  (left),
    .match (row_byte == col_byte),
    .cost  (cell_cost)
  );

  // string stores: one write and one read per cycle each, sharing one address
  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[first_addr] <= item.char_code;
    end
    first_rd <= first_mem[first_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[second_addr] <= item.char_code;
    end
    second_rd <= second_mem[second_addr];
  end

  // cost row: read at i, written back at i in the calc step
  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      cost_mem[i] <= cell_cost;
    end
    cost_rd <= cost_mem[i];
  end

  // sequencer, lengths and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      swap          <= 1'b0;
      i             <= '0;
      j             <= '0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.action == ACT_FIRST) begin
              if (wr_first) first_length <= first_length + LW'(1);
              else          overflow_seen <= 1'b1;
            end else if (item.action == ACT_SECOND) begin
              if (wr_second) second_length <= second_length + LW'(1);
              else           overflow_seen <= 1'b1;
            end else if (item.action == ACT_COMPUTE) begin
              swap          <= (first_length > second_length);
              na            <= (first_length > second_length) ? second_length : first_length;
              nb            <= (first_length > second_length) ? first_length : second_length;
              ovf_hold      <= overflow_seen;
              first_length  <= '0;
              second_length <= '0;
              overflow_seen <= 1'b0;
              i             <= '0;
              j             <= '0;
              diag          <= '0;
              left          <= CW'(1);
              if (first_length == '0 || second_length == '0) begin
                final_cost <= CW'((first_length > second_length) ? first_length
                                                                 : second_length);
                state      <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          diag <= up;
          left <= cell_cost;
          if (last_i) begin
            if (last_j) begin
              final_cost <= cell_cost;
              state      <= S_DONE;
            end else begin
              i     <= '0;
              j     <= j + IDX_W'(1);
              diag  <= CW'(j) + CW'(1);
              left  <= CW'(j) + CW'(2);
              state <= S_READ;
            end
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid    <= 1'b1;
            result.distance <= DIST_W'(final_cost);
            result.overflow <= ovf_hold;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/ed_cell.sv */
// Shared cost unit: one dynamic-programming cell, min of the three edit paths.
module ed_cell import ed_pkg::*; #(
  parameter int CW = 9
) (
  input  logic [CW-1:0] diag,
  input  logic [CW-1:0] up,
  input  logic [CW-1:0] left,
  input  logic          match,
  output logic [CW-1:0] cost
);

  logic [CW-1:0] sub_cost;
  logic [CW-1:0] del_cost;
  logic [CW-1:0] ins_cost;
  logic [CW-1:0] min_ab;

  // substitute costs nothing on a match
  assign sub_cost = match ? diag : diag + CW'(1);
  assign del_cost = up + CW'(1);
  assign ins_cost = left + CW'(1);

  assign min_ab = (sub_cost < del_cost) ? sub_cost : del_cost;
  assign cost   = (min_ab < ins_cost) ? min_ab : ins_cost;

endmodule

/* design/ed_checker.sv */
// Port-level checks for the edit distance engine, bound to the top level.
module ed_checker import ed_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  // a compute request leaves the engine stalled in the cycle after acceptance
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.action == ACT_COMPUTE |=> item_stall)
    else $error("engine took a request right after a compute");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // distance never exceeds the string capacity
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (int'(result.distance) <= MAX_LEN))
    else $error("distance beyond string capacity");

endmodule

bind edit_distance_engine ed_checker #(.MAX_LEN(MAX_LEN)) u_ed_checker (.*);
